FILE: rtl/core/barometer_compensation_defines.svh
// Assertion macros shared by the barometer compensation checker.
// Depends on nothing; expects clk_i and rst_ni in the scope of use.
`ifndef BAROMETER_COMPENSATION_DEFINES_SVH
`define BAROMETER_COMPENSATION_DEFINES_SVH

// checked only outside reset
`define BC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define BC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/bc_pkg.sv
// Shared types and constants for the barometer compensation block.
// No dependencies.
package bc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_CAL_A = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_CAL_B = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_CAL_C = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_OSS   = 8'd3;

  localparam logic [1:0]  OssReset   = 2'd3;
  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] KP1        = 32'd3038;
  localparam logic [31:0] KP2        = 32'hFFFF_E343; // -7357
  localparam logic [31:0] KP3        = 32'd3791;
  localparam logic [31:0] KScale     = 32'd50000;
  localparam logic [31:0] KBias      = 32'd32768;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic signed [31:0] pressure;
    logic               divide_error;
  } out_word_t;

  typedef struct packed {
    logic [63:0] cal_a;
    logic [63:0] cal_b;
    logic [31:0] cal_c;
    logic [1:0]  oss;
  } cal_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] sh);
    return $unsigned($signed(v) >>> sh);
  endfunction

endpackage

FILE: rtl/core/bc_fifo.sv
// Short queue between the accept side and the compute engine.
// Depends on bc_pkg for the word type.
module bc_fifo #(
  parameter int unsigned Depth = bc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bc_pkg::in_word_t data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output bc_pkg::in_word_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bc_pkg::in_word_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/bc_divider.sv
// 32-bit unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
module bc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, den_q;
  logic [32:0] rem_sh, diff;

  assign rem_sh = {rem_q, quo_q[31]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/bc_engine.sv
// Compute engine: sequencer over one shared 32x32 multiplier and the divider.
// Depends on bc_pkg and bc_divider.
module bc_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bc_pkg::cal_t      cal_i,
  input  logic              head_valid_i,
  input  bc_pkg::in_word_t  head_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output bc_pkg::out_word_t res_o,
  input  logic              res_ack_i
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T0   = 5'd1;
  localparam logic [4:0] S_T1   = 5'd2;
  localparam logic [4:0] S_TDIV = 5'd3;
  localparam logic [4:0] S_T2   = 5'd4;
  localparam logic [4:0] S_P1   = 5'd5;
  localparam logic [4:0] S_P2   = 5'd6;
  localparam logic [4:0] S_P3   = 5'd7;
  localparam logic [4:0] S_P4   = 5'd8;
  localparam logic [4:0] S_P5   = 5'd9;
  localparam logic [4:0] S_P6   = 5'd10;
  localparam logic [4:0] S_P7   = 5'd11;
  localparam logic [4:0] S_PDIV = 5'd12;
  localparam logic [4:0] S_P8   = 5'd13;
  localparam logic [4:0] S_P9   = 5'd14;
  localparam logic [4:0] S_P10  = 5'd15;
  localparam logic [4:0] S_P11  = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bc_pkg::sext16(cal_i.cal_a[15:0]);
  assign ac2 = bc_pkg::sext16(cal_i.cal_a[31:16]);
  assign ac3 = bc_pkg::sext16(cal_i.cal_a[47:32]);
  assign ac4 = {16'd0, cal_i.cal_a[63:48]};
  assign ac5 = {16'd0, cal_i.cal_b[15:0]};
  assign ac6 = {16'd0, cal_i.cal_b[31:16]};
  assign b1  = bc_pkg::sext16(cal_i.cal_b[47:32]);
  assign b2  = bc_pkg::sext16(cal_i.cal_b[63:48]);
  assign mc  = bc_pkg::sext16(cal_i.cal_c[15:0]);
  assign md  = bc_pkg::sext16(cal_i.cal_c[31:16]);

  logic [4:0]  st_q, st_d;
  logic [15:0] ut_q;
  logic [23:0] up_q;
  logic [31:0] prod_q, prod_d, ma, mb;
  logic [31:0] x1_q, x1_d, t0_q, t0_d, b6_q, b6_d, sq_q, sq_d;
  logic [31:0] b3_q, b3_d, b4_q, b4_d, p_q, p_d;
  logic        neg_q, neg_d, b7hi_q, b7hi_d;
  bc_pkg::out_word_t res_q, res_d;

  logic        div_start, div_done;
  logic [31:0] div_num, div_den, div_quo;

  bc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  logic [31:0] tden, tnum, tq, b5, tsc, ts, x3, tt, tv, b7, up_sh, scale, pq, pa;

  always_comb begin
    st_d      = st_q;
    prod_d    = prod_q;
    ma        = '0;
    mb        = '0;
    x1_d      = x1_q;
    t0_d      = t0_q;
    b6_d      = b6_q;
    sq_d      = sq_q;
    b3_d      = b3_q;
    b4_d      = b4_q;
    p_d       = p_q;
    neg_d     = neg_q;
    b7hi_d    = b7hi_q;
    res_d     = res_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    tden      = bc_pkg::asr32(prod_q, 5'd15) + md;
    tnum      = mc << 11;
    tq        = neg_q ? (32'd0 - div_quo) : div_quo;
    b5        = x1_q + tq;
    tsc       = bc_pkg::asr32((b5 << 3) + (b5 << 1) + 32'd8, 5'd4);
    ts        = tsc;
    x3        = '0;
    tt        = '0;
    tv        = '0;
    b7        = prod_q;
    up_sh     = {8'd0, up_q} >> (4'd8 - {2'd0, cal_i.oss});
    scale     = bc_pkg::KScale >> cal_i.oss;
    pq        = b7hi_q ? (div_quo << 1) : div_quo;
    pa        = bc_pkg::asr32(pq, 5'd8);

    case (st_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          st_d  = S_T0;
        end
      end
      S_T0: begin
        ma   = {16'd0, ut_q} - ac6;
        mb   = ac5;
        st_d = S_T1;
      end
      S_T1: begin
        x1_d = bc_pkg::asr32(prod_q, 5'd15);
        if (tden == '0) begin
          res_d = '{temperature: '0, pressure: '0, divide_error: 1'b1};
          st_d  = S_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = tnum[31] ? (32'd0 - tnum) : tnum;
          div_den   = tden[31] ? (32'd0 - tden) : tden;
          neg_d     = tnum[31] ^ tden[31];
          st_d      = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_done) begin
          st_d = S_T2;
        end
      end
      S_T2: begin
        // saturate to 16 bits
        if ($signed(tsc) > 32'sd32767) begin
          ts = 32'd32767;
        end else if ($signed(tsc) < -32'sd32768) begin
          ts = 32'hFFFF_8000;
        end
        res_d.temperature  = ts[15:0];
        res_d.divide_error = 1'b0;
        b6_d = b5 - bc_pkg::TempOffset;
        ma   = b6_d;
        mb   = b6_d;
        st_d = S_P1;
      end
      S_P1: begin
        sq_d = bc_pkg::asr32(prod_q, 5'd12);
        ma   = b2;
        mb   = sq_d;
        st_d = S_P2;
      end
      S_P2: begin
        t0_d = bc_pkg::asr32(prod_q, 5'd11);
        ma   = ac2;
        mb   = b6_q;
        st_d = S_P3;
      end
      S_P3: begin
        x3   = t0_q + bc_pkg::asr32(prod_q, 5'd11);
        tt   = ((ac1 << 2) + x3) << cal_i.oss;
        tv   = tt + 32'd2;
        b3_d = tv[31] ? (32'd0 - ((32'd0 - tv) >> 2)) : (tv >> 2);
        ma   = ac3;
        mb   = b6_q;
        st_d = S_P4;
      end
      S_P4: begin
        t0_d = bc_pkg::asr32(prod_q, 5'd13);
        ma   = b1;
        mb   = sq_q;
        st_d = S_P5;
      end
      S_P5: begin
        x3   = bc_pkg::asr32(t0_q + bc_pkg::asr32(prod_q, 5'd16) + 32'd2, 5'd2);
        ma   = ac4;
        mb   = x3 + bc_pkg::KBias;
        st_d = S_P6;
      end
      S_P6: begin
        b4_d = prod_q >> 15;
        if (b4_d == '0) begin
          res_d = '{temperature: '0, pressure: '0, divide_error: 1'b1};
          st_d  = S_DONE;
        end else begin
          ma   = up_sh - b3_q;
          mb   = scale;
          st_d = S_P7;
        end
      end
      S_P7: begin
        b7hi_d    = b7[31];
        div_start = 1'b1;
        div_num   = b7[31] ? b7 : (b7 << 1);
        div_den   = b4_q;
        st_d      = S_PDIV;
      end
      S_PDIV: begin
        if (div_done) begin
          st_d = S_P8;
        end
      end
      S_P8: begin
        p_d  = pq;
        ma   = pa;
        mb   = pa;
        st_d = S_P9;
      end
      S_P9: begin
        ma   = prod_q;
        mb   = bc_pkg::KP1;
        st_d = S_P10;
      end
      S_P10: begin
        t0_d = bc_pkg::asr32(prod_q, 5'd16);
        ma   = bc_pkg::KP2;
        mb   = p_q;
        st_d = S_P11;
      end
      S_P11: begin
        res_d.pressure = p_q + bc_pkg::asr32(
          t0_q + bc_pkg::asr32(prod_q, 5'd16) + bc_pkg::KP3, 5'd4);
        st_d = S_DONE;
      end
      S_DONE: begin
        if (res_ack_i) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
    prod_d = ma * mb;
  end

  assign res_valid_o = (st_q == S_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ut_q <= head_i.raw_temperature;
      up_q <= head_i.raw_pressure;
    end
    prod_q <= prod_d;
    x1_q   <= x1_d;
    t0_q   <= t0_d;
    b6_q   <= b6_d;
    sq_q   <= sq_d;
    b3_q   <= b3_d;
    b4_q   <= b4_d;
    p_q    <= p_d;
    neg_q  <= neg_d;
    b7hi_q <= b7hi_d;
    res_q  <= res_d;
  end

endmodule

FILE: rtl/core/barometer_compensation.sv
// Top level of the barometer compensation block: config registers, input
// queue, compute engine and output register. Depends on bc_pkg, bc_fifo, bc_engine.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_word_i): one word holds a raw
//    temperature and a raw pressure reading. Words queue in a short FIFO,
//    so the sender is stalled only when the FIFO is full.
//  - Output channel (out_valid_o/out_ready_i/out_word_o): one word per input
//    word: temperature in 0.01 degC, pressure in Pa, divide_error flag.
//  - Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always
//    ready; index 0..3 selects cal_word_a, cal_word_b, cal_word_c,
//    oversampling. Other indexes are dropped. Write only while idle.
//  - The engine works on one word at a time and pops the next only after
//    its result is taken: two waits on the shared bit-serial divider
//    (temperature, then pressure) plus one step per cycle on a
//    single 32x32 multiplier.
//  - A zero divisor ends the word early: divide_error set, results zero.
//  - Reset clears the calibration words, sets oversampling to 3 and empties
//    the FIFO and the output register.
//  - When the receiver stalls, the result waits in the output register, the
//    engine holds its finished word, and the FIFO keeps taking input until it is full.
module barometer_compensation #(
  parameter int unsigned QueueDepth = bc_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bc_pkg::in_word_t             in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bc_pkg::out_word_t            out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bc_pkg::CfgDataW-1:0]  cfg_data_i
);

  bc_pkg::cal_t cal_q;

  // config writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.cal_a <= '0;
      cal_q.cal_b <= '0;
      cal_q.cal_c <= '0;
      cal_q.oss   <= bc_pkg::OssReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bc_pkg::REG_CAL_A: cal_q.cal_a <= cfg_data_i;
        bc_pkg::REG_CAL_B: cal_q.cal_b <= cfg_data_i;
        bc_pkg::REG_CAL_C: cal_q.cal_c <= cfg_data_i[31:0];
        bc_pkg::REG_OSS:   cal_q.oss   <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept into queue
  logic             q_full, q_empty, q_pop, q_push;
  bc_pkg::in_word_t q_head;

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  bc_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (in_word_i),
    .full_o (q_full),
    .empty_o(q_empty),
    .pop_i  (q_pop),
    .data_o (q_head)
  );

  // back: compute
  logic              res_valid, res_ack;
  bc_pkg::out_word_t res;

  bc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal_q),
    .head_valid_i(!q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (res_ack)
  );

  // output register
  logic              out_valid_q;
  bc_pkg::out_word_t out_word_q;

  assign res_ack = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: rtl/core/bc_checker.sv
// Port-level checks for barometer_compensation, bound to the top level.
// Depends on bc_pkg and barometer_compensation_defines.svh.
`include "barometer_compensation_defines.svh"

module bc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input bc_pkg::out_word_t           out_word_o
);

  // an error word carries zeroed results
  `BC_ASSERT(a_err_zero,
    out_valid_o && out_word_o.divide_error |->
      out_word_o.temperature == 16'sd0 && out_word_o.pressure == 32'sd0,
    "error word with nonzero result")

  // a stalled word is held
  `BC_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o),
    "output word dropped or changed while stalled")

  // nothing is offered in reset
  `BC_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind barometer_compensation bc_checker u_bc_checker (.*);

FILE: dv/barometer_compensation_tb.sv
// Testbench for barometer_compensation: random and directed readings under several
// calibration settings, each result checked against a local integer predictor.
// Depends on bc_pkg and the barometer_compensation RTL.
module barometer_compensation_tb;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  bc_pkg::in_word_t in_word;
  logic out_valid;
  logic out_ready;
  bc_pkg::out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [bc_pkg::CfgIdxW-1:0] cfg_index;
  logic [bc_pkg::CfgDataW-1:0] cfg_data;

  // local copy of the calibration registers
  logic [63:0] cal_a;
  logic [63:0] cal_b;
  logic [31:0] cal_c;
  logic [1:0] oss;

  bc_pkg::in_word_t pending_words[$];    // readings waiting to be sent
  bc_pkg::out_word_t expected_words[$];  // compensated results still to come
  int unsigned sent_cnt;
  int unsigned accept_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned gap_left;

  barometer_compensation u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // arithmetic right shift of a wrapped 32-bit value (rounds toward -inf)
  function automatic logic [31:0] shift_floor(logic [31:0] v, int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // datasheet integer compensation, all intermediates wrap at 32 bits
  function automatic bc_pkg::out_word_t compensate(bc_pkg::in_word_t w);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq, t2, dv, pr;
    logic signed [31:0] ts;
    bc_pkg::out_word_t r;
    r = '0;
    r.divide_error = 1'b1;
    ac1 = sx16(cal_a[15:0]);
    ac2 = sx16(cal_a[31:16]);
    ac3 = sx16(cal_a[47:32]);
    ac4 = {16'd0, cal_a[63:48]};
    ac5 = {16'd0, cal_b[15:0]};
    ac6 = {16'd0, cal_b[31:16]};
    b1  = sx16(cal_b[47:32]);
    b2  = sx16(cal_b[63:48]);
    mc  = sx16(cal_c[15:0]);
    md  = sx16(cal_c[31:16]);
    ut  = {16'd0, w.raw_temperature};
    up  = {8'd0, w.raw_pressure};

    x1 = shift_floor((ut - ac6) * ac5, 15);
    dv = x1 + md;
    if (dv == 32'd0) return r;
    x2 = $signed(mc << 11) / $signed(dv);
    b5 = x1 + x2;
    ts = $signed(shift_floor(b5 * 32'd10 + 32'd8, 4));
    if (ts > 32767) ts = 32767;
    if (ts < -32768) ts = -32768;

    b6 = b5 - bc_pkg::TempOffset;
    sq = shift_floor(b6 * b6, 12);
    x1 = shift_floor(b2 * sq, 11);
    x2 = shift_floor(ac2 * b6, 11);
    x3 = x1 + x2;
    t2 = ((ac1 * 32'd4 + x3) << oss) + 32'd2;
    b3 = t2[31] ? 32'd0 - ((32'd0 - t2) / 32'd4) : t2 / 32'd4;
    x1 = shift_floor(ac3 * b6, 13);
    x2 = shift_floor(b1 * sq, 16);
    x3 = shift_floor(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + bc_pkg::KBias)) >> 15;
    if (b4 == 32'd0) return r;
    b7 = ((up >> (32'd8 - oss)) - b3) * (bc_pkg::KScale >> oss);
    p = !b7[31] ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
    x1 = shift_floor(p, 8) * shift_floor(p, 8);
    x1 = shift_floor(x1 * bc_pkg::KP1, 16);
    x2 = shift_floor(bc_pkg::KP2 * p, 16);
    pr = p + shift_floor(x1 + x2 + bc_pkg::KP3, 4);

    r.temperature = ts[15:0];
    r.pressure = pr;
    r.divide_error = 1'b0;
    return r;
  endfunction

  // Driver: words go out in bursts with random gaps; a word stays put
  // until the monitor has counted its handshake.
  always @(negedge clk) begin
    logic nxt_valid;
    bc_pkg::in_word_t nxt_word;
    nxt_valid = in_valid;
    nxt_word = in_word;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && !(in_valid && accept_cnt < sent_cnt)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0) begin
        nxt_word = pending_words.pop_front();
        nxt_valid = 1'b1;
        sent_cnt <= sent_cnt + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          // every other long stretch runs back to back
          gap_left <= cycle_cnt[13] ? 0 : $urandom_range(0, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
    in_valid <= nxt_valid;
    in_word <= nxt_word;

    // receiver stall pattern cycles through four modes
    case (cycle_cnt[12:11])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (cycle_cnt % 23) < 5;
      default: out_ready <= $urandom_range(0, 9) != 0;
    endcase
  end

  // Monitor: predict on input handshake, compare on output handshake.
  always @(posedge clk) begin
    bc_pkg::out_word_t exp_w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_words.push_back(compensate(in_word));
        accept_cnt <= accept_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, out_word);
          err_cnt <= err_cnt + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.temperature !== out_word.temperature) begin
            $display("%0t: temperature expected %0d actual %0d", $time,
                     exp_w.temperature, out_word.temperature);
            err_cnt <= err_cnt + 1;
          end
          if (exp_w.pressure !== out_word.pressure) begin
            $display("%0t: pressure expected %0d actual %0d", $time,
                     exp_w.pressure, out_word.pressure);
            err_cnt <= err_cnt + 1;
          end
          if (exp_w.divide_error !== out_word.divide_error) begin
            $display("%0t: divide_error expected %0b actual %0b", $time,
                     exp_w.divide_error, out_word.divide_error);
            err_cnt <= err_cnt + 1;
          end
        end
      end
    end
  end

  task automatic cfg_write(logic [bc_pkg::CfgIdxW-1:0] idx,
                           logic [bc_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bc_pkg::REG_CAL_A: cal_a = data;
      bc_pkg::REG_CAL_B: cal_b = data;
      bc_pkg::REG_CAL_C: cal_c = data[31:0];
      bc_pkg::REG_OSS:   oss = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cal_write(logic [63:0] a, logic [63:0] b, logic [31:0] c, logic [1:0] o);
    cfg_write(bc_pkg::REG_CAL_A, a);
    cfg_write(bc_pkg::REG_CAL_B, b);
    cfg_write(bc_pkg::REG_CAL_C, {32'd0, c});
    cfg_write(bc_pkg::REG_OSS, {62'd0, o});
  endtask

  // half full-range readings, half in the range a real sensor gives
  task automatic add_random(int unsigned n);
    bc_pkg::in_word_t w;
    repeat (n) begin
      if ($urandom_range(0, 1)) begin
        w.raw_temperature = 16'($urandom);
        w.raw_pressure = 24'($urandom);
      end else begin
        w.raw_temperature = 16'($urandom_range(20000, 36000));
        w.raw_pressure = 24'($urandom_range(4000000, 12000000));
      end
      pending_words.push_back(w);
    end
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // typical factory calibration from a datasheet example
  localparam logic [63:0] CalTypA = {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408};
  localparam logic [63:0] CalTypB = {16'd4, 16'd6190, 16'd23153, 16'd32757};
  localparam logic [31:0] CalTypC = {16'd2868, 16'hDDE9};

  initial begin
    bc_pkg::in_word_t w;
    rst_n = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cal_a = '0;
    cal_b = '0;
    cal_c = '0;
    oss = bc_pkg::OssReset;
    sent_cnt = 0;
    accept_cnt = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    burst_left = 1;
    gap_left = 0;
    // clean falling edge on the reset before the first clock edge
    #1;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset calibration: md is zero, so every word hits the temperature divisor
    add_random(20);
    drain();

    // typical calibration at each oversampling setting, with field extremes at setting 0
    for (int o = 0; o < 4; o++) begin
      cal_write(CalTypA, CalTypB, CalTypC, o[1:0]);
      if (o == 0) begin
        w.raw_temperature = 16'd27898; w.raw_pressure = 24'd23843 << 8;
        pending_words.push_back(w);
        w.raw_temperature = 16'd0;     w.raw_pressure = 24'd0;
        pending_words.push_back(w);
        w.raw_temperature = 16'hFFFF;  w.raw_pressure = 24'hFFFFFF;
        pending_words.push_back(w);
        w.raw_temperature = 16'd0;     w.raw_pressure = 24'hFFFFFF;
        pending_words.push_back(w);
        w.raw_temperature = 16'hFFFF;  w.raw_pressure = 24'd0;
        pending_words.push_back(w);
        w.raw_temperature = 16'h8000;  w.raw_pressure = 24'h800000;
        pending_words.push_back(w);
      end
      add_random(150);
      drain();
    end

    // ac4 zero: pressure divisor is zero while the temperature path is fine
    cal_write({16'd0, CalTypA[47:0]}, CalTypB, CalTypC, 2'd1);
    add_random(10);
    drain();

    // extreme coefficients push the temperature into saturation
    cal_write(64'hFFFF_7FFF_8000_7FFF, 64'h7FFF_8000_0000_FFFF, {16'h0001, 16'h7FFF}, 2'd3);
    add_random(60);
    drain();
    cal_write(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 2'd0);
    add_random(60);
    drain();

    // writes to unused indexes must leave the registers alone
    cfg_write(bc_pkg::REG_OSS + 8'd1, 64'h0123_4567_89AB_CDEF);
    cfg_write(8'hFF, '1);
    add_random(20);
    drain();

    // random calibration words
    for (int k = 0; k < 6; k++) begin
      cal_write({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                2'($urandom_range(0, 3)));
      add_random(150);
      drain();
    end

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bc_pkg.sv
rtl/core/bc_fifo.sv
rtl/core/bc_divider.sv
rtl/core/bc_engine.sv
rtl/core/barometer_compensation.sv
rtl/core/bc_checker.sv
dv/barometer_compensation_tb.sv
